// ===== src/gbn_pkg.sv =====
// Shared types, constants and helpers for the go-back-N sender core.
// Depends on nothing; imported by go_back_n_sender_core.
package gbn_pkg;

  // Sizing of the sender
  localparam int WINDOW_SIZE  = 6;
  localparam int BUFFER_DEPTH = 64;
  localparam int NWORDS       = 5;

  localparam int WORD_W  = 32;
  localparam int SEQ_W   = 31;
  localparam int PTR_W   = $clog2(BUFFER_DEPTH);
  localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int WIN_W   = $clog2(WINDOW_SIZE + 1);
  localparam int PAY_W   = NWORDS * WORD_W;
  // Ring entry: payload words plus their precomputed 32-bit sum on top
  localparam int ENTRY_W = PAY_W + WORD_W;

  // Stream widths
  localparam int IN_DATA_W  = 3 * WORD_W + PAY_W;
  localparam int OUT_RAW_W  = SEQ_W + WORD_W + PAY_W + 2 + 2;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

  // Input kinds (tuser)
  localparam logic [1:0] MODE_MSG = 2'd0;
  localparam logic [1:0] MODE_ACK = 2'd1;
  localparam logic [1:0] MODE_EXP = 2'd2;

  // Timer commands
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // One result word
  typedef struct packed {
    logic              pkt;
    logic [SEQ_W-1:0]  seq;
    logic [WORD_W-1:0] chk;
    logic [PAY_W-1:0]  words;
    logic [1:0]        timer;
    logic [1:0]        status;
    logic              last;
  } result_t;

  // Result with no packet, single and final for its input
  function automatic result_t empty_result(logic [1:0] status, logic [1:0] timer);
    result_t r;
    r        = '0;
    r.timer  = timer;
    r.status = status;
    r.last   = 1'b1;
    return r;
  endfunction

  // Ring pointer advance, wrapping at the buffer depth (offset never above depth)
  function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] ptr, logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(ptr) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(BUFFER_DEPTH)) begin
      sum = sum - (CNT_W+1)'(BUFFER_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Packet checksum: inverted sum of seq, -1 and the payload sum
  function automatic logic [WORD_W-1:0] pkt_checksum(logic [SEQ_W-1:0] seq,
                                                     logic [WORD_W-1:0] wsum);
    logic [WORD_W-1:0] s;
    s = WORD_W'(seq) + {WORD_W{1'b1}} + wsum;
    return ~s;
  endfunction

endpackage

// ===== src/go_back_n_sender_core.sv =====
// Go-back-N sender core: ring buffer memory, window control and result output.
// Depends on gbn_pkg.
//
// The core takes one word on s_* and produces one to WINDOW_SIZE result words
// on m_*, the final one flagged with m_tlast. Every input first passes S_SUM1
// and S_SUM2 of a shared adder (payload sum for a message, checksum check for
// an acknowledgement), then the decision state S_EXEC, which waits for a free
// output register; a message, a rejected or empty acknowledgement and an
// ignored expiry then end with a single result. Each packet sent from the ring
// passes S_RD for the synchronous read of the ring memory and then S_EMIT to
// present the result, which waits for a free output register. The output
// register lets a new word be taken while the last result still waits. No
// clearing pass is needed after reset: only ring entries that hold messages
// are ever read.
module go_back_n_sender_core
  import gbn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: ack_seq_field, ack_number, ack_checksum, payload_word_0..4
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // tuser: mode
  input  logic [1:0]            s_tuser,
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata: seq_out, checksum_out, out_word_0..4, timer_cmd, status, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // tuser: packet_valid
  output logic                  m_tuser,
  output logic                  m_tlast
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM1 = 3'd1;
  localparam logic [2:0] S_SUM2 = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]            state;

  // Latched input word
  logic [1:0]            in_mode;
  logic [IN_DATA_W-1:0]  in_data;
  logic [WORD_W-1:0]     acc;

  // Ring control
  logic [PTR_W-1:0]      head_ptr;
  logic [CNT_W-1:0]      held;
  logic [SEQ_W-1:0]      head_seq;
  logic [SEQ_W-1:0]      next_seq;

  // Send loop
  logic [WIN_W-1:0]      pos;
  logic [WIN_W-1:0]      send_end;
  logic                  first;
  logic [1:0]            timer_pend;
  logic [SEQ_W-1:0]      seq_reg;

  // Ring memory
  logic [ENTRY_W-1:0]    mem [BUFFER_DEPTH];
  logic [ENTRY_W-1:0]    rd_data;
  logic                  mem_we;
  logic [PTR_W-1:0]      wr_slot;
  logic [PTR_W-1:0]      rd_slot;

  // Output register
  logic                  out_valid;
  result_t               out_res;
  result_t               out_res_next;
  logic                  out_free;
  logic                  out_load;
  logic                  loop_start;

  // Decision terms
  logic [WORD_W-1:0]     f_seq, f_num, f_chk;
  logic [WORD_W-1:0]     f_w [NWORDS];
  logic                  msg_refuse;
  logic                  ack_ok;
  logic [WORD_W-1:0]     span;
  logic [CNT_W-1:0]      acked;
  logic [CNT_W-1:0]      new_held;
  logic [WIN_W-1:0]      from_pos;
  logic [WIN_W-1:0]      to_pos;
  logic [WIN_W-1:0]      inwin;
  logic                  last_pkt;

  // Field views of the latched input
  always_comb begin
    f_seq = in_data[WORD_W-1:0];
    f_num = in_data[2*WORD_W-1:WORD_W];
    f_chk = in_data[3*WORD_W-1:2*WORD_W];
    for (int w = 0; w < NWORDS; w++) begin
      f_w[w] = in_data[(3+w)*WORD_W +: WORD_W];
    end
  end

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE);

  // Decision logic for the EXEC state, and the read slot and last-packet test of the send loop
  always_comb begin
    wr_slot    = ptr_add(head_ptr, held);
    msg_refuse = (held >= CNT_W'(BUFFER_DEPTH)) || (next_seq == SEQ_MAX);
    ack_ok     = (~acc == f_chk);
    span       = {1'b0, f_num[SEQ_W-1:0]} - {1'b0, head_seq} + WORD_W'(1);
    if (!f_num[WORD_W-1] && (f_num[SEQ_W-1:0] >= head_seq)) begin
      acked = (span < WORD_W'(held)) ? span[CNT_W-1:0] : held;
    end else begin
      acked = '0;
    end
    new_held = held - acked;
    from_pos = (acked >= CNT_W'(WINDOW_SIZE)) ? '0 : WIN_W'(CNT_W'(WINDOW_SIZE) - acked);
    to_pos   = (new_held < CNT_W'(WINDOW_SIZE)) ? new_held[WIN_W-1:0]
                                                : WIN_W'(WINDOW_SIZE);
    inwin    = (held < CNT_W'(WINDOW_SIZE)) ? held[WIN_W-1:0] : WIN_W'(WINDOW_SIZE);
    rd_slot  = ptr_add(head_ptr, CNT_W'(pos));
    last_pkt = ((pos + WIN_W'(1)) == send_end);
    mem_we   = (state == S_EXEC) && out_free && (in_mode == MODE_MSG) && !msg_refuse;
  end

  // Next result word, and whether EXEC hands over to the ring read loop
  always_comb begin
    loop_start   = 1'b0;
    out_res_next = empty_result(ST_OK, TMR_NONE);
    if (state == S_EMIT) begin
      out_res_next.pkt   = 1'b1;
      out_res_next.seq   = seq_reg;
      out_res_next.chk   = pkt_checksum(seq_reg, rd_data[ENTRY_W-1:PAY_W]);
      out_res_next.words = rd_data[PAY_W-1:0];
      out_res_next.timer = first ? timer_pend : TMR_NONE;
      out_res_next.last  = last_pkt;
    end else begin
      unique case (in_mode)
        MODE_MSG: begin
          if (msg_refuse) begin
            out_res_next.status = ST_REFUSED;
          end else if (held < CNT_W'(WINDOW_SIZE)) begin
            // New message lands inside the window: send it now
            out_res_next.pkt   = 1'b1;
            out_res_next.seq   = next_seq;
            out_res_next.chk   = pkt_checksum(next_seq, acc);
            out_res_next.words = {f_w[4], f_w[3], f_w[2], f_w[1], f_w[0]};
            out_res_next.timer = (held == '0) ? TMR_START : TMR_NONE;
          end
        end
        MODE_ACK: begin
          if (!ack_ok) begin
            out_res_next.status = ST_CORRUPT;
          end else if ((held != '0) && (acked != '0)) begin
            if (acked == held) begin
              out_res_next.timer = TMR_STOP;
            end else if (from_pos < to_pos) begin
              // Send the packets that entered the window
              loop_start = 1'b1;
            end else begin
              out_res_next.timer = TMR_RESTART;
            end
          end
        end
        MODE_EXP: begin
          // Resend the whole window
          loop_start = (held != '0);
        end
        default: begin
        end
      endcase
    end
    out_load = out_free && ((state == S_EMIT) || ((state == S_EXEC) && !loop_start));
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_slot] <= {acc, f_w[4], f_w[3], f_w[2], f_w[1], f_w[0]};
    end
    if (state == S_RD) begin
      rd_data <= mem[rd_slot];
    end
  end

  // Sequencer, ring control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_ptr  <= '0;
      held      <= '0;
      head_seq  <= '0;
      next_seq  <= '0;
      out_valid <= 1'b0;
      first     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_res   <= out_res_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_mode <= s_tuser;
            in_data <= s_tdata;
            state   <= S_SUM1;
          end
        end
        // Shared adder, first half
        S_SUM1: begin
          if (in_mode == MODE_MSG) begin
            acc <= f_w[0] + f_w[1] + f_w[2] + f_w[3];
          end else begin
            acc <= f_seq + f_num + f_w[0] + f_w[1];
          end
          state <= S_SUM2;
        end
        // Shared adder, second half
        S_SUM2: begin
          if (in_mode == MODE_MSG) begin
            acc <= acc + f_w[4];
          end else begin
            acc <= acc + f_w[2] + f_w[3] + f_w[4];
          end
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            state <= loop_start ? S_RD : S_IDLE;
            unique case (in_mode)
              MODE_MSG: begin
                if (!msg_refuse) begin
                  held     <= held + CNT_W'(1);
                  next_seq <= next_seq + SEQ_W'(1);
                  if (held == '0) begin
                    head_seq <= next_seq;
                  end
                end
              end
              MODE_ACK: begin
                if (ack_ok && (held != '0) && (acked != '0)) begin
                  head_ptr <= ptr_add(head_ptr, acked);
                  head_seq <= head_seq + SEQ_W'(acked);
                  held     <= new_held;
                end
              end
              default: begin
              end
            endcase
            // Set up the ring read loop
            if (loop_start) begin
              pos        <= (in_mode == MODE_EXP) ? '0 : from_pos;
              send_end   <= (in_mode == MODE_EXP) ? inwin : to_pos;
              timer_pend <= (in_mode == MODE_EXP) ? TMR_START : TMR_RESTART;
              first      <= 1'b1;
            end
          end
        end
        // Ring read issued; sequence of this slot
        S_RD: begin
          seq_reg <= head_seq + SEQ_W'(pos);
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            first <= 1'b0;
            pos   <= pos + WIN_W'(1);
            state <= last_pkt ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result stream
  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.pkt;
  assign m_tlast  = out_res.last;
  assign m_tdata  = {(OUT_DATA_W - OUT_RAW_W)'(0), out_res.status, out_res.timer,
                     out_res.words, out_res.chk, out_res.seq};

  // Ring never holds more than its depth
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(BUFFER_DEPTH))
    else $error("ring fill count beyond buffer depth");

  // Packets only ever go out with ok status
  a_pkt_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (out_res.status == ST_OK))
    else $error("packet result with non-ok status");

  // An accepted word starts the adder
  a_accept_sum: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_SUM1))
    else $error("accepted word did not enter the adder");

  // Send loop never runs past the window
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (pos < send_end))
    else $error("send position past end of range");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for go_back_n_sender_core: directed and random stimulus,
// an in-bench prediction of the ring and window, random idling on both streams.
// Depends on gbn_pkg and go_back_n_sender_core.
`timescale 1ns / 1ps

module tb_top;
  import gbn_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP   = 60;

  // One input word before packing
  typedef struct packed {
    logic [1:0]             mode;
    logic [31:0]            seqf;
    logic [31:0]            acknum;
    logic [31:0]            chk;
    logic [NWORDS-1:0][31:0] words;
  } sender_item_t;

  // One result word after unpacking
  typedef struct packed {
    logic                    pkt;
    logic [SEQ_W-1:0]        seq;
    logic [31:0]             chk;
    logic [NWORDS-1:0][31:0] words;
    logic [1:0]              timer;
    logic [1:0]              status;
    logic                    last;
  } tx_word_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  go_back_n_sender_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  sender_item_t pending_items[$];
  tx_word_t     tx_expect_q[$];
  sender_item_t cur_item;
  int           err_cnt = 0;
  int           cycle_cnt = 0;
  int           send_gap = 0;
  int           recv_stall = 0;
  logic         quiet;

  // Shadow state of the sender
  logic [NWORDS-1:0][31:0] ring_words [BUFFER_DEPTH];
  logic [PTR_W-1:0]        ring_head = '0;
  logic [CNT_W-1:0]        ring_held = '0;
  logic [SEQ_W-1:0]        seq_head = '0;
  logic [SEQ_W-1:0]        seq_next = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle count, idle-free stretches and run limit
  assign quiet = (cycle_cnt[10:9] == 2'b11);
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** go_back_n_sender_core: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < PRINT_CAP)
      $display("mismatch @%0d: %s got %h want %h", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  // Packet for ring position pos (0 = oldest held)
  function automatic tx_word_t make_packet(int pos);
    tx_word_t r;
    int slot;
    logic [SEQ_W-1:0] sq;
    logic [31:0] sum;
    r = '0;
    slot = (int'(ring_head) + pos) % BUFFER_DEPTH;
    sq = seq_head + SEQ_W'(pos);
    sum = 32'(sq) + 32'hFFFF_FFFF;
    for (int w = 0; w < NWORDS; w++) sum += ring_words[slot][w];
    r.pkt = 1'b1;
    r.seq = sq;
    r.chk = ~sum;
    r.words = ring_words[slot];
    return r;
  endfunction

  // Expected results of one accepted word; updates the shadow state
  task automatic predict_sender(input sender_item_t it);
    tx_word_t   outs[$];
    tx_word_t   r;
    logic [1:0] tmr;
    logic [1:0] st;
    logic [31:0] sum;
    logic [32:0] span;
    int inwin, acked, from, upto, slot;
    bit was_empty;
    tmr = TMR_NONE;
    st = ST_OK;
    inwin = (ring_held < WINDOW_SIZE) ? int'(ring_held) : WINDOW_SIZE;
    case (it.mode)
      MODE_MSG: begin
        if (ring_held >= BUFFER_DEPTH || seq_next == SEQ_MAX) begin
          st = ST_REFUSED;
        end else begin
          slot = (int'(ring_head) + int'(ring_held)) % BUFFER_DEPTH;
          was_empty = (ring_held == 0);
          ring_words[slot] = it.words;
          if (was_empty) seq_head = seq_next;
          ring_held = ring_held + 1'b1;
          seq_next = seq_next + 1'b1;
          if (ring_held <= WINDOW_SIZE) begin
            outs.push_back(make_packet(int'(ring_held) - 1));
            if (was_empty) tmr = TMR_START;
          end
        end
      end
      MODE_ACK: begin
        sum = it.seqf + it.acknum;
        for (int w = 0; w < NWORDS; w++) sum += it.words[w];
        if (~sum != it.chk) begin
          st = ST_CORRUPT;
        end else if (ring_held != 0) begin
          acked = 0;
          if (!it.acknum[31] && it.acknum >= 32'(seq_head)) begin
            span = 33'(it.acknum) - 33'(seq_head) + 33'd1;
            acked = (span < 33'(ring_held)) ? int'(span) : int'(ring_held);
          end
          if (acked > 0) begin
            ring_head = PTR_W'((int'(ring_head) + acked) % BUFFER_DEPTH);
            seq_head = seq_head + SEQ_W'(acked);
            ring_held = ring_held - CNT_W'(acked);
            if (ring_held == 0) begin
              tmr = TMR_STOP;
            end else begin
              // send what newly slid into the window
              tmr = TMR_RESTART;
              from = (acked >= WINDOW_SIZE) ? 0 : WINDOW_SIZE - acked;
              upto = (ring_held < WINDOW_SIZE) ? int'(ring_held) : WINDOW_SIZE;
              for (int p = from; p < upto; p++) outs.push_back(make_packet(p));
            end
          end
        end
      end
      MODE_EXP: begin
        if (ring_held != 0) begin
          tmr = TMR_START;
          for (int p = 0; p < inwin; p++) outs.push_back(make_packet(p));
        end
      end
      default: ;
    endcase
    if (outs.size() == 0) outs.push_back('0);
    foreach (outs[k]) begin
      r = outs[k];
      r.timer = (k == 0) ? tmr : TMR_NONE;
      r.status = st;
      r.last = (k == outs.size() - 1);
      tx_expect_q.push_back(r);
    end
  endtask

  // Driver: present pending words, random gap after each accepted one
  always @(posedge clk) begin
    logic v;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      v = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_sender(cur_item);
        v = 1'b0;
        send_gap = quiet ? 0 : $urandom_range(0, 9);
      end
      if (!v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          s_tdata <= {cur_item.words, cur_item.chk, cur_item.acknum, cur_item.seqf};
          s_tuser <= cur_item.mode;
          v = 1'b1;
        end
      end
      s_tvalid <= v;
    end
  end

  task automatic cmp_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Monitor: check each result word, random stall after each one
  always @(posedge clk) begin
    tx_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (tx_expect_q.size() == 0) begin
          report_mismatch("unexpected result, seq", 32'(m_tdata[30:0]), 32'h0);
        end else begin
          want = tx_expect_q.pop_front();
          cmp_field("packet_valid", 32'(m_tuser), 32'(want.pkt));
          cmp_field("seq_out", 32'(m_tdata[30:0]), 32'(want.seq));
          cmp_field("checksum_out", m_tdata[62:31], want.chk);
          for (int w = 0; w < NWORDS; w++)
            cmp_field($sformatf("out_word_%0d", w), m_tdata[63 + 32*w +: 32], want.words[w]);
          cmp_field("timer_cmd", 32'(m_tdata[224:223]), 32'(want.timer));
          cmp_field("status", 32'(m_tdata[226:225]), 32'(want.status));
          cmp_field("last", 32'(m_tlast), 32'(want.last));
        end
        recv_stall = quiet ? 0 : $urandom_range(0, 9);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Keep the pending queue short so choices track the shadow state
  task automatic enqueue(input sender_item_t it);
    while (pending_items.size() != 0) @(posedge clk);
    pending_items.push_back(it);
  endtask

  task automatic push_msg(logic [31:0] fill, bit rand_fill);
    sender_item_t it;
    it = '0;
    it.mode = MODE_MSG;
    it.seqf = $urandom;
    it.acknum = $urandom;
    it.chk = $urandom;
    for (int w = 0; w < NWORDS; w++) it.words[w] = rand_fill ? $urandom : fill;
    enqueue(it);
  endtask

  task automatic push_ack(logic [31:0] seqf, logic [31:0] num, bit good);
    sender_item_t it;
    logic [31:0] sum;
    it = '0;
    it.mode = MODE_ACK;
    it.seqf = seqf;
    it.acknum = num;
    for (int w = 0; w < NWORDS; w++) it.words[w] = $urandom;
    sum = seqf + num;
    for (int w = 0; w < NWORDS; w++) sum += it.words[w];
    it.chk = ~sum;
    if (!good) it.chk ^= 32'h1 << $urandom_range(0, 31);
    enqueue(it);
  endtask

  task automatic push_other(logic [1:0] mode);
    sender_item_t it;
    it.mode = mode;
    it.seqf = $urandom;
    it.acknum = $urandom;
    it.chk = $urandom;
    for (int w = 0; w < NWORDS; w++) it.words[w] = $urandom;
    enqueue(it);
  endtask

  // Ack number near the held range, sometimes far off
  function automatic logic [31:0] pick_ack_number();
    logic [31:0] base;
    int span;
    base = 32'(seq_head);
    span = (ring_held > 0) ? int'(ring_held) - 1 : 0;
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return base - 1;
      7: return 32'(seq_next) + $urandom_range(0, 3);
      8: return $urandom;
      default: return base + $urandom_range(0, span);
    endcase
  endfunction

  // Stimulus and end of run
  initial begin
    int burst;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty ring cases, window edge, resend, partial and full acks
    push_ack(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    push_other(MODE_EXP);
    push_other(MODE_UNUSED);
    push_msg(32'h0000_0000, 1'b0);
    push_msg(32'hFFFF_FFFF, 1'b0);
    repeat (4) push_msg(32'h0, 1'b1);
    push_msg(32'h0, 1'b1);
    push_ack(32'h7FFF_FFFF, 32'd0, 1'b0);
    push_ack(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    push_other(MODE_EXP);
    push_ack(32'hFFFF_FFFF, 32'd0, 1'b1);
    push_ack($urandom, 32'd2, 1'b1);
    push_ack($urandom, 32'h7FFF_FFFE, 1'b1);
    push_ack($urandom, 32'h8000_0000, 1'b1);
    push_msg(32'h0, 1'b1);
    push_ack($urandom, 32'h8000_0000, 1'b1);
    push_ack($urandom, 32'h7FFF_FFFF, 1'b1);

    // Fill the ring past its depth, then free many at once
    repeat (BUFFER_DEPTH + 2) push_msg(32'h0, 1'b1);
    push_other(MODE_EXP);
    while (pending_items.size() != 0) @(posedge clk);
    push_ack($urandom, 32'(seq_head) + 32'd19, 1'b1);
    push_other(MODE_EXP);
    push_ack($urandom, 32'(seq_next), 1'b1);

    // Random traffic, mostly well-formed
    for (int i = 0; i < 240; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: push_msg(32'h0, 1'b1);
        8: begin
          burst = $urandom_range(2, 8);
          repeat (burst) push_msg(32'h0, 1'b1);
        end
        9, 10, 11, 12, 13: begin
          while (pending_items.size() != 0) @(posedge clk);
          push_ack($urandom, pick_ack_number(), 1'b1);
        end
        14, 15: push_ack($urandom, pick_ack_number(), 1'b0);
        16, 17, 18: push_other(MODE_EXP);
        default: push_other(MODE_UNUSED);
      endcase
    end

    // Drain and let the core settle
    while (pending_items.size() != 0 || s_tvalid) @(posedge clk);
    while (tx_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** go_back_n_sender_core: PASSED **");
    end else begin
      $display("** go_back_n_sender_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/gbn_pkg.sv
src/go_back_n_sender_core.sv
test/tb_top.sv
